>>> rtl/int_to_decimal_ascii_assert.svh
// Assertion macros used by the checker file of the decimal text converter.
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, held off during reset
`define ITDA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define ITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/itda_pkg.sv
// Types and constants shared by the decimal text converter modules.
`default_nettype none

package itda_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic find;
		logic sel_sign;
		logic next_digit;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic neg;
		logic last_digit;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/itda_datapath.sv
// Datapath: magnitude shift register, shift-add-3 BCD converter and character select.
`default_nettype none

module itda_datapath import itda_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cmd_t                          cmd,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output sts_t                               sts,
	output logic [7:0]                         char_code,
	output logic                               is_last
);

	localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BCD_W = 4 * NDIG;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       adj;
	logic [CNT_W-1:0]       bitcnt_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       hi;
	logic [3:0]             dig;

	assign raw    = value;
	assign mag_in = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

	always_comb begin
		for (int k = 0; k < NDIG; k++) begin
			if (bcd_q[4*k +: 4] >= 4'd5)
				adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
			else
				adj[4*k +: 4] = bcd_q[4*k +: 4];
		end
	end

	always_comb begin
		hi = '0;
		for (int k = 0; k < NDIG; k++) begin
			if (bcd_q[4*k +: 4] != 4'd0)
				hi = IDX_W'(k);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_in;
			neg_q <= raw[VALUE_WIDTH-1];
			bcd_q <= '0;
		end else if (cmd.shift) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitcnt_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.load)
				bitcnt_q <= CNT_W'(VALUE_WIDTH - 1);
			else if (cmd.shift)
				bitcnt_q <= bitcnt_q - 1'b1;
			if (cmd.find)
				idx_q <= hi;
			else if (cmd.next_digit)
				idx_q <= idx_q - 1'b1;
		end
	end

	assign dig            = bcd_q[4*idx_q +: 4];
	assign sts.conv_done  = (bitcnt_q == '0);
	assign sts.neg        = neg_q;
	assign sts.last_digit = (idx_q == '0);

	assign char_code = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, dig});
	assign is_last   = !cmd.sel_sign && (idx_q == '0);

endmodule

`default_nettype wire

>>> rtl/itda_ctrl.sv
// Controller: sequences load, conversion, leading-digit search and character output.
`default_nettype none

module itda_ctrl import itda_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_CONV;
			end
			ST_CONV: begin
				if (sts.conv_done)
					state_d = ST_FIND;
			end
			ST_FIND: begin
				state_d = sts.neg ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				if (out_ready)
					state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (out_ready && sts.last_digit)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
			end
			ST_FIND: begin
				cmd.find = 1'b1;
			end
			ST_SIGN: begin
				out_valid    = 1'b1;
				cmd.sel_sign = 1'b1;
			end
			ST_DIGIT: begin
				out_valid      = 1'b1;
				cmd.next_digit = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII text converter.
// Takes one two's complement integer per word and returns its decimal text, most significant
// character first, one character per output word, with is_last on the final character.
// Negative values lead with '-'; zero gives a single '0'; the most negative value is exact.
// One integer at a time: the accept, the one-bit-per-cycle shift-add-3 BCD conversion of all
// VALUE_WIDTH bits, the search for the leading digit, then one character per cycle while
// out_ready is high.
`default_nettype none

module int_to_decimal_ascii import itda_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         char_code,
	output logic                               is_last
);

	cmd_t cmd;
	sts_t sts;

	itda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	itda_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (value),
		.sts       (sts),
		.char_code (char_code),
		.is_last   (is_last)
	);

endmodule

`default_nettype wire

>>> rtl/itda_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
`default_nettype none

`include "int_to_decimal_ascii_assert.svh"

module itda_checker import itda_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] char_code,
	input wire logic       is_last
);

	`ITDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_code) && $stable(is_last), "output word changed while stalled")
	`ITDA_ASSERT_NOW(a_char_range, out_valid, char_code == CHAR_MINUS || (char_code >= CHAR_ZERO && char_code <= CHAR_NINE), "character outside minus sign and digits")
	`ITDA_ASSERT_NOW(a_minus_not_last, out_valid && char_code == CHAR_MINUS, !is_last, "minus sign marked as last character")
	`ITDA_ASSERT_NEXT(a_no_input_mid_text, out_valid && out_ready && !is_last, !in_ready && out_valid, "text broken off before its last character")

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);

`default_nettype wire
